// ===== rtl/lpvo_pkg.sv =====
`timescale 1ns / 1ps

package lpvo_pkg;

    // Fixed-point format of positions, velocities and gains
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int DT_W    = 16;
    localparam int VAL_W   = 32;
    localparam int RECIP_W = 24;
    localparam int GAIN_W  = 17;
    localparam int IDX_W   = 3;

    // Datapath widths: differences, multiplier operands, product, scaled product, sums
    localparam int DIFF_W = VAL_W + 1;
    localparam int MUL_A_W = 43;
    localparam int MUL_B_W = RECIP_W + 1;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int SH_W = 52;
    localparam int SUM_W = SH_W + 2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_INV_TAU    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_POS_GAIN   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PV_GAIN    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_VEL_GAIN   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_INIT_POS   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_INIT_VEL   = 3'd5;

    // Register reset values
    localparam logic [RECIP_W-1:0] INV_TAU_RST  = 24'd1310720;
    localparam logic [GAIN_W-1:0]  POS_GAIN_RST = 17'd13107;
    localparam logic [RECIP_W-1:0] PV_GAIN_RST  = 24'd786432;
    localparam logic [GAIN_W-1:0]  VEL_GAIN_RST = 17'd9830;

    // Sequencer states: P* multiply, W* write back the scaled product
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P1,
        ST_W1,
        ST_P2,
        ST_W2,
        ST_P3,
        ST_W3,
        ST_ERR,
        ST_P5,
        ST_W5,
        ST_W6,
        ST_P7,
        ST_W7,
        ST_P8,
        ST_W8,
        ST_OUT
    } t_state;

    // Write-back operation of the datapath
    typedef enum logic [2:0] {
        WB_NONE,
        WB_LOAD,
        WB_ACC,
        WB_VEL,
        WB_POS,
        WB_ERR,
        WB_T,
        WB_VEL_EV
    } t_wb;

    typedef struct packed {
        t_wb  wb;
        logic mul_en;
        logic opb_pvg;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [RECIP_W-1:0] inv_tau;
        logic [GAIN_W-1:0]  pos_gain;
        logic [RECIP_W-1:0] pv_gain;
        logic [GAIN_W-1:0]  vel_gain;
    } t_cfg;

    typedef struct packed {
        logic             pos_we;
        logic             vel_we;
        logic [VAL_W-1:0] value;
    } t_init_load;

    // Clamp a wide sum to the signed 32-bit range
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-VAL_W:0] top;
        top = v[SUM_W-1:VAL_W-1];
        if (top == '0 || top == '1) begin
            return v[VAL_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== rtl/lpvo_ifs.sv =====
`timescale 1ns / 1ps

// Sample channel
interface lpvo_in_if;
    logic                                valid;
    logic                                ready;
    logic        [lpvo_pkg::DT_W-1:0]    time_step;
    logic signed [lpvo_pkg::VAL_W-1:0]   measured_pos;
    logic signed [lpvo_pkg::VAL_W-1:0]   measured_vel;
    logic signed [lpvo_pkg::VAL_W-1:0]   commanded_vel;

    modport source (
        output valid, time_step, measured_pos, measured_vel, commanded_vel,
        input  ready
    );
    modport sink (
        input  valid, time_step, measured_pos, measured_vel, commanded_vel,
        output ready
    );
endinterface

// Estimate channel
interface lpvo_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lpvo_pkg::VAL_W-1:0]   estimated_pos;
    logic signed [lpvo_pkg::VAL_W-1:0]   estimated_vel;

    modport source (
        output valid, estimated_pos, estimated_vel,
        input  ready
    );
    modport sink (
        input  valid, estimated_pos, estimated_vel,
        output ready
    );
endinterface

// Register write channel
interface lpvo_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lpvo_pkg::IDX_W-1:0]          index;
    logic [lpvo_pkg::VAL_W-1:0]          data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== rtl/lpvo_cfg_regs.sv =====
`timescale 1ns / 1ps

module lpvo_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lpvo_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [lpvo_pkg::VAL_W-1:0]    i_cfg_data,
    output lpvo_pkg::t_cfg                o_cfg,
    output lpvo_pkg::t_init_load          o_init
);

    lpvo_pkg::t_cfg r_cfg;

    // Gain and time-constant registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_tau  <= lpvo_pkg::INV_TAU_RST;
            r_cfg.pos_gain <= lpvo_pkg::POS_GAIN_RST;
            r_cfg.pv_gain  <= lpvo_pkg::PV_GAIN_RST;
            r_cfg.vel_gain <= lpvo_pkg::VEL_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lpvo_pkg::CFG_INV_TAU:  r_cfg.inv_tau  <= i_cfg_data[lpvo_pkg::RECIP_W-1:0];
                lpvo_pkg::CFG_POS_GAIN: r_cfg.pos_gain <= i_cfg_data[lpvo_pkg::GAIN_W-1:0];
                lpvo_pkg::CFG_PV_GAIN:  r_cfg.pv_gain  <= i_cfg_data[lpvo_pkg::RECIP_W-1:0];
                lpvo_pkg::CFG_VEL_GAIN: r_cfg.vel_gain <= i_cfg_data[lpvo_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Initial-value writes go straight to the estimate registers
    assign o_init.pos_we = i_cfg_we && (i_cfg_index == lpvo_pkg::CFG_INIT_POS);
    assign o_init.vel_we = i_cfg_we && (i_cfg_index == lpvo_pkg::CFG_INIT_VEL);
    assign o_init.value  = i_cfg_data;
    assign o_cfg         = r_cfg;

endmodule

// ===== rtl/lpvo_ctrl.sv =====
`timescale 1ns / 1ps

module lpvo_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lpvo_pkg::t_cmd  o_cmd
);

    lpvo_pkg::t_state r_state;
    lpvo_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    // State and output-word flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpvo_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequence: one multiply then one write-back per dependent product
    always_comb begin
        n_state        = r_state;
        o_cmd.wb       = lpvo_pkg::WB_NONE;
        o_cmd.mul_en   = 1'b0;
        o_cmd.opb_pvg  = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            lpvo_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.wb = lpvo_pkg::WB_LOAD;
                    n_state  = lpvo_pkg::ST_P1;
                end
            end
            lpvo_pkg::ST_P1: begin
                o_cmd.mul_en = 1'b1;
                n_state      = lpvo_pkg::ST_W1;
            end
            lpvo_pkg::ST_W1: begin
                o_cmd.wb = lpvo_pkg::WB_ACC;
                n_state  = lpvo_pkg::ST_P2;
            end
            lpvo_pkg::ST_P2: begin
                o_cmd.mul_en = 1'b1;
                n_state      = lpvo_pkg::ST_W2;
            end
            lpvo_pkg::ST_W2: begin
                o_cmd.wb = lpvo_pkg::WB_VEL;
                n_state  = lpvo_pkg::ST_P3;
            end
            lpvo_pkg::ST_P3: begin
                o_cmd.mul_en = 1'b1;
                n_state      = lpvo_pkg::ST_W3;
            end
            lpvo_pkg::ST_W3: begin
                o_cmd.wb = lpvo_pkg::WB_POS;
                n_state  = lpvo_pkg::ST_ERR;
            end
            lpvo_pkg::ST_ERR: begin
                o_cmd.wb = lpvo_pkg::WB_ERR;
                n_state  = lpvo_pkg::ST_P5;
            end
            lpvo_pkg::ST_P5: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.opb_pvg = 1'b1;
                n_state       = lpvo_pkg::ST_W5;
            end
            lpvo_pkg::ST_W5: begin
                // position correction lands while the gain-times-error product starts
                o_cmd.wb     = lpvo_pkg::WB_POS;
                o_cmd.mul_en = 1'b1;
                n_state      = lpvo_pkg::ST_W6;
            end
            lpvo_pkg::ST_W6: begin
                o_cmd.wb = lpvo_pkg::WB_T;
                n_state  = lpvo_pkg::ST_P7;
            end
            lpvo_pkg::ST_P7: begin
                o_cmd.mul_en = 1'b1;
                n_state      = lpvo_pkg::ST_W7;
            end
            lpvo_pkg::ST_W7: begin
                o_cmd.wb = lpvo_pkg::WB_VEL_EV;
                n_state  = lpvo_pkg::ST_P8;
            end
            lpvo_pkg::ST_P8: begin
                o_cmd.mul_en = 1'b1;
                n_state      = lpvo_pkg::ST_W8;
            end
            lpvo_pkg::ST_W8: begin
                o_cmd.wb = lpvo_pkg::WB_VEL;
                n_state  = lpvo_pkg::ST_OUT;
            end
            lpvo_pkg::ST_OUT: begin
                // wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = lpvo_pkg::ST_IDLE;
                end
            end
            default: n_state = lpvo_pkg::ST_IDLE;
        endcase
    end

    // Output word flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_in_ready  = (r_state == lpvo_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    // A load never overwrites a word that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");

    // An accepted word starts the first multiply
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == lpvo_pkg::ST_P1))
        else $error("accepted word did not start the sequence");

    // A new output word appears only from the output step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == lpvo_pkg::ST_OUT))
        else $error("output valid raised outside the output step");

    // The write-backs in W1, W2 and W8 each follow a multiply
    a_wb_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpvo_pkg::ST_W1 || r_state == lpvo_pkg::ST_W2 ||
         r_state == lpvo_pkg::ST_W8) |-> $past(o_cmd.mul_en))
        else $error("write-back without a fresh product");

endmodule

// ===== rtl/lpvo_dpath.sv =====
`timescale 1ns / 1ps

module lpvo_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lpvo_pkg::t_cmd                      i_cmd,
    input  lpvo_pkg::t_cfg                      i_cfg,
    input  lpvo_pkg::t_init_load                i_init,
    input  logic        [lpvo_pkg::DT_W-1:0]    i_time_step,
    input  logic signed [lpvo_pkg::VAL_W-1:0]   i_measured_pos,
    input  logic signed [lpvo_pkg::VAL_W-1:0]   i_measured_vel,
    input  logic signed [lpvo_pkg::VAL_W-1:0]   i_commanded_vel,
    output logic signed [lpvo_pkg::VAL_W-1:0]   o_estimated_pos,
    output logic signed [lpvo_pkg::VAL_W-1:0]   o_estimated_vel
);

    localparam int VW = lpvo_pkg::VAL_W;
    localparam int DW = lpvo_pkg::DIFF_W;
    localparam int AW = lpvo_pkg::MUL_A_W;
    localparam int BW = lpvo_pkg::MUL_B_W;
    localparam int PW = lpvo_pkg::PROD_W;
    localparam int HW = lpvo_pkg::SH_W;
    localparam int SW = lpvo_pkg::SUM_W;

    // Estimates (architectural state)
    logic signed [VW-1:0] r_pos, n_pos;
    logic signed [VW-1:0] r_vel, n_vel;
    // Sample fields and intermediate values
    logic [lpvo_pkg::DT_W-1:0] r_dt, n_dt;
    logic signed [VW-1:0] r_mp, n_mp;
    logic signed [VW-1:0] r_mv, n_mv;
    logic signed [DW-1:0] r_ev, n_ev;
    // Shared multiplier operands and product
    logic signed [AW-1:0] r_opa, n_opa;
    logic signed [BW-1:0] r_opb, n_opb;
    logic signed [PW-1:0] r_prod;
    // Output word
    logic signed [VW-1:0] r_est_pos, r_est_vel;

    logic signed [PW-1:0] w_prod_sh;
    logic signed [HW-1:0] w_shift;
    logic signed [SW-1:0] w_shift_ext;
    logic signed [VW-1:0] w_acc;
    logic signed [VW-1:0] w_vel_sat;
    logic signed [VW-1:0] w_pos_sat;
    logic signed [DW-1:0] w_cmd_diff;
    logic signed [DW-1:0] w_ep;
    logic signed [DW-1:0] w_ev;
    logic        [BW-1:0] w_dt_b;

    // Floor-scaled product, and the sums that consume it
    assign w_prod_sh   = r_prod >>> lpvo_pkg::FRAC_BITS;
    assign w_shift     = w_prod_sh[HW-1:0];
    assign w_shift_ext = {{(SW-HW){w_shift[HW-1]}}, w_shift};
    assign w_acc       = lpvo_pkg::sat32(w_shift_ext);
    assign w_vel_sat   = lpvo_pkg::sat32(w_shift_ext + {{(SW-VW){r_vel[VW-1]}}, r_vel});
    assign w_pos_sat   = lpvo_pkg::sat32(w_shift_ext + {{(SW-VW){r_pos[VW-1]}}, r_pos});

    // Exact 33-bit differences
    assign w_cmd_diff = {i_commanded_vel[VW-1], i_commanded_vel} - {r_vel[VW-1], r_vel};
    assign w_ep       = {r_mp[VW-1], r_mp} - {r_pos[VW-1], r_pos};
    assign w_ev       = {r_mv[VW-1], r_mv} - {r_vel[VW-1], r_vel};
    assign w_dt_b     = {{(BW-lpvo_pkg::DT_W){1'b0}}, r_dt};

    // Write-back selection
    always_comb begin
        n_pos = r_pos;
        n_vel = r_vel;
        n_dt  = r_dt;
        n_mp  = r_mp;
        n_mv  = r_mv;
        n_ev  = r_ev;
        n_opa = r_opa;
        n_opb = r_opb;
        if (i_cmd.opb_pvg) begin
            n_opb = {1'b0, i_cfg.pv_gain};
        end
        unique case (i_cmd.wb)
            lpvo_pkg::WB_NONE: ;
            lpvo_pkg::WB_LOAD: begin
                n_dt  = i_time_step;
                n_mp  = i_measured_pos;
                n_mv  = i_measured_vel;
                n_opa = {{(AW-DW){w_cmd_diff[DW-1]}}, w_cmd_diff};
                n_opb = {1'b0, i_cfg.inv_tau};
            end
            lpvo_pkg::WB_ACC: begin
                n_opa = {{(AW-VW){w_acc[VW-1]}}, w_acc};
                n_opb = w_dt_b;
            end
            lpvo_pkg::WB_VEL: begin
                n_vel = w_vel_sat;
                n_opa = {{(AW-VW){w_vel_sat[VW-1]}}, w_vel_sat};
                n_opb = w_dt_b;
            end
            lpvo_pkg::WB_POS: begin
                n_pos = w_pos_sat;
            end
            lpvo_pkg::WB_ERR: begin
                n_opa = {{(AW-DW){w_ep[DW-1]}}, w_ep};
                n_ev  = w_ev;
                n_opb = {{(BW-lpvo_pkg::GAIN_W){1'b0}}, i_cfg.pos_gain};
            end
            lpvo_pkg::WB_T: begin
                // gain times error stays within 42 signed bits after scaling
                n_opa = w_shift[AW-1:0];
                n_opb = w_dt_b;
            end
            lpvo_pkg::WB_VEL_EV: begin
                n_vel = w_vel_sat;
                n_opa = {{(AW-DW){r_ev[DW-1]}}, r_ev};
                n_opb = {{(BW-lpvo_pkg::GAIN_W){1'b0}}, i_cfg.vel_gain};
            end
            default: ;
        endcase
        // the user must make initial-value writes only while idle; the block itself does not enforce it
        if (i_init.pos_we) begin
            n_pos = i_init.value;
        end
        if (i_init.vel_we) begin
            n_vel = i_init.value;
        end
    end

    // Estimates reset to the initial-value reset of zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0;
        end else begin
            r_pos <= n_pos;
            r_vel <= n_vel;
        end
    end

    // Payload registers, the shared multiplier and the output word
    always_ff @(posedge i_clk) begin
        r_dt  <= n_dt;
        r_mp  <= n_mp;
        r_mv  <= n_mv;
        r_ev  <= n_ev;
        r_opa <= n_opa;
        r_opb <= n_opb;
        if (i_cmd.mul_en) begin
            r_prod <= r_opa * r_opb;
        end
        if (i_cmd.out_load) begin
            r_est_pos <= r_pos;
            r_est_vel <= r_vel;
        end
    end

    assign o_estimated_pos = r_est_pos;
    assign o_estimated_vel = r_est_vel;

endmodule

// ===== rtl/luenberger_position_velocity_observer_top.sv =====
`timescale 1ns / 1ps
// A new sample is taken only after the estimate of the last one is loaded into the result word.
// Seven dependent products share one 43x25 multiplier; each is floor-scaled, and all but one
// are then saturated, most of them after being added to an estimate.
// Reset: synchronous, active low; gains return to defaults and both estimates to zero.
// Register writes are taken in every cycle; initial values load the estimates at once.

module luenberger_position_velocity_observer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpvo_in_if.sink     i_in,
    lpvo_out_if.source  o_out,
    lpvo_cfg_if.sink    i_cfg
);

    lpvo_pkg::t_cmd       w_cmd;
    lpvo_pkg::t_cfg       w_cfg;
    lpvo_pkg::t_init_load w_init;
    logic                 w_in_ready;
    logic                 w_out_valid;

    assign i_cfg.ready = 1'b1;

    // Gain registers and initial-value writes
    lpvo_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_cfg       (w_cfg),
        .o_init      (w_init)
    );

    // Sequencer
    lpvo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and estimates
    lpvo_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg           (w_cfg),
        .i_init          (w_init),
        .i_time_step     (i_in.time_step),
        .i_measured_pos  (i_in.measured_pos),
        .i_measured_vel  (i_in.measured_vel),
        .i_commanded_vel (i_in.commanded_vel),
        .o_estimated_pos (o_out.estimated_pos),
        .o_estimated_vel (o_out.estimated_vel)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

endmodule

// ===== test/luenberger_position_velocity_observer_top_test.sv =====
`timescale 1ns / 1ps

module luenberger_position_velocity_observer_top_test;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 4;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 32;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 100;
    localparam int PHASE_ITEMS   = 325;
    localparam int SEGMENTS      = 4;
    localparam int NOISE_SPAN    = 32'h0020_0000;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    localparam logic signed [lpvo_pkg::VAL_W-1:0] V_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [lpvo_pkg::VAL_W-1:0] V_MIN = 32'sh8000_0000;
    localparam logic [lpvo_pkg::DT_W-1:0]         DT_MAX = 16'hFFFF;

    // Indexes past the register list; writes there must change nothing
    localparam logic [lpvo_pkg::IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [lpvo_pkg::IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        [lpvo_pkg::DT_W-1:0]  time_step;
        logic signed [lpvo_pkg::VAL_W-1:0] measured_pos;
        logic signed [lpvo_pkg::VAL_W-1:0] measured_vel;
        logic signed [lpvo_pkg::VAL_W-1:0] commanded_vel;
    } t_sample_word;

    typedef struct packed {
        logic signed [lpvo_pkg::VAL_W-1:0] estimated_pos;
        logic signed [lpvo_pkg::VAL_W-1:0] estimated_vel;
    } t_estimate_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpvo_in_if  in_ch();
    lpvo_out_if out_ch();
    lpvo_cfg_if cfg_ch();

    luenberger_position_velocity_observer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Observer copy: gains and the two estimates, all held as 64-bit integers
    longint inv_tau_q  = longint'(lpvo_pkg::INV_TAU_RST);
    longint pos_gain_q = longint'(lpvo_pkg::POS_GAIN_RST);
    longint pv_gain_q  = longint'(lpvo_pkg::PV_GAIN_RST);
    longint vel_gain_q = longint'(lpvo_pkg::VEL_GAIN_RST);
    longint track_pos  = 0;
    longint track_vel  = 0;

    t_estimate_word expected_estimates[$];
    int fail_count     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;

    function automatic longint clamp32(input longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // Predict then correct; >>> on a signed value floors, as the scaling requires
    function automatic t_estimate_word predict_estimate(input t_sample_word s);
        longint dt, cmd, pos, vel, acc, ep, ev, t;
        t_estimate_word e;
        dt  = longint'(s.time_step);
        cmd = longint'($signed(s.commanded_vel));
        pos = track_pos;
        vel = track_vel;
        acc = clamp32(((cmd - vel) * inv_tau_q) >>> lpvo_pkg::FRAC_BITS);
        vel = clamp32(vel + ((acc * dt) >>> lpvo_pkg::FRAC_BITS));
        pos = clamp32(pos + ((vel * dt) >>> lpvo_pkg::FRAC_BITS));
        // errors taken after prediction, exact in 33 bits
        ep  = longint'($signed(s.measured_pos)) - pos;
        ev  = longint'($signed(s.measured_vel)) - vel;
        pos = clamp32(pos + ((pos_gain_q * ep) >>> lpvo_pkg::FRAC_BITS));
        t   = (pv_gain_q * ep) >>> lpvo_pkg::FRAC_BITS;
        vel = clamp32(vel + ((t * dt) >>> lpvo_pkg::FRAC_BITS));
        vel = clamp32(vel + ((vel_gain_q * ev) >>> lpvo_pkg::FRAC_BITS));
        track_pos = pos;
        track_vel = vel;
        e.estimated_pos = pos[lpvo_pkg::VAL_W-1:0];
        e.estimated_vel = vel[lpvo_pkg::VAL_W-1:0];
        return e;
    endfunction

    function automatic void apply_reg(input logic [lpvo_pkg::IDX_W-1:0] idx,
                                      input logic [lpvo_pkg::VAL_W-1:0] data);
        case (idx)
            lpvo_pkg::CFG_INV_TAU:  inv_tau_q  = longint'(data[lpvo_pkg::RECIP_W-1:0]);
            lpvo_pkg::CFG_POS_GAIN: pos_gain_q = longint'(data[lpvo_pkg::GAIN_W-1:0]);
            lpvo_pkg::CFG_PV_GAIN:  pv_gain_q  = longint'(data[lpvo_pkg::RECIP_W-1:0]);
            lpvo_pkg::CFG_VEL_GAIN: vel_gain_q = longint'(data[lpvo_pkg::GAIN_W-1:0]);
            lpvo_pkg::CFG_INIT_POS: track_pos  = longint'($signed(data));
            lpvo_pkg::CFG_INIT_VEL: track_vel  = longint'($signed(data));
            default: ;
        endcase
    endfunction

    function automatic logic [lpvo_pkg::VAL_W-1:0] rand_reg_value(
        input logic [lpvo_pkg::IDX_W-1:0] idx);
        case (idx)
            lpvo_pkg::CFG_INV_TAU, lpvo_pkg::CFG_PV_GAIN: begin
                return ($urandom_range(1) != 0) ? $urandom : $urandom_range(0, 32'h0030_0000);
            end
            lpvo_pkg::CFG_POS_GAIN, lpvo_pkg::CFG_VEL_GAIN: begin
                // mostly in range, sometimes full words to hit the masked upper bits
                return ($urandom_range(4) == 0) ? $urandom : $urandom_range(0, 65536);
            end
            default: begin
                return ($urandom_range(1) != 0) ? $urandom
                                                : $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            end
        endcase
    endfunction

    function automatic logic [lpvo_pkg::VAL_W-1:0] pick_edge_value();
        case ($urandom_range(4))
            0: return V_MAX;
            1: return V_MIN;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly measurements that follow the estimates, the rest noise and edge values
    function automatic t_sample_word make_random_sample();
        t_sample_word s;
        int kind;
        kind = $urandom_range(9);
        if (kind < 6) begin
            s.time_step     = lpvo_pkg::DT_W'($urandom_range(0, 6554));
            s.measured_pos  = lpvo_pkg::VAL_W'(track_pos)
                              + ($urandom_range(0, NOISE_SPAN) - NOISE_SPAN / 2);
            s.measured_vel  = lpvo_pkg::VAL_W'(track_vel)
                              + ($urandom_range(0, NOISE_SPAN) - NOISE_SPAN / 2);
            s.commanded_vel = lpvo_pkg::VAL_W'(track_vel)
                              + ($urandom_range(0, NOISE_SPAN) - NOISE_SPAN / 2);
        end else if (kind < 8) begin
            s.time_step     = lpvo_pkg::DT_W'($urandom_range(0, 65535));
            s.measured_pos  = $urandom;
            s.measured_vel  = $urandom;
            s.commanded_vel = $urandom;
        end else begin
            case ($urandom_range(3))
                0: s.time_step = '0;
                1: s.time_step = DT_MAX;
                2: s.time_step = 16'd1;
                default: s.time_step = lpvo_pkg::DT_W'($urandom_range(0, 65535));
            endcase
            s.measured_pos  = pick_edge_value();
            s.measured_vel  = pick_edge_value();
            s.commanded_vel = pick_edge_value();
        end
        return s;
    endfunction

    // Send one sample word; valid stays high afterwards so back-to-back words need no gap
    task automatic send_sample(input t_sample_word s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.time_step     <= s.time_step;
        in_ch.measured_pos  <= s.measured_pos;
        in_ch.measured_vel  <= s.measured_vel;
        in_ch.commanded_vel <= s.commanded_vel;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        expected_estimates.push_back(predict_estimate(s));
    endtask

    // Block idle: input quiet, all estimates back, then a settling wait for the sequencer
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (expected_estimates.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lpvo_pkg::IDX_W-1:0] idx,
                             input logic [lpvo_pkg::VAL_W-1:0] data);
        settle_block();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        apply_reg(idx, data);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic report_mismatch(input string field, input logic [lpvo_pkg::VAL_W-1:0] want,
                                   input logic [lpvo_pkg::VAL_W-1:0] got);
        if (fail_count < MAX_REPORTS) begin
            $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
        end
        fail_count++;
    endtask

    // ---- directed tests ----

    task automatic test_reset_state();
        send_sample('{16'd0, 32'sd0, 32'sd0, 32'sd0});
        send_sample('{16'd655, 32'sh0001_0000, 32'sh0000_8000, 32'sh0002_0000});
        send_sample('{DT_MAX, V_MAX, V_MAX, V_MAX});
    endtask

    task automatic test_field_extremes();
        send_sample('{DT_MAX, V_MIN, V_MIN, V_MIN});
        send_sample('{DT_MAX, V_MAX, V_MIN, V_MAX});
        send_sample('{16'd1, V_MIN, V_MAX, V_MIN});
        send_sample('{16'h8000, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F});
    endtask

    task automatic test_gain_extremes();
        // full-word data: upper bits beyond each register width are dropped
        write_reg(lpvo_pkg::CFG_INV_TAU, '1);
        write_reg(lpvo_pkg::CFG_POS_GAIN, '1);
        write_reg(lpvo_pkg::CFG_PV_GAIN, '1);
        write_reg(lpvo_pkg::CFG_VEL_GAIN, '1);
        send_sample('{DT_MAX, V_MAX, V_MIN, V_MAX});
        send_sample('{DT_MAX, V_MIN, V_MAX, V_MIN});
        write_reg(lpvo_pkg::CFG_INV_TAU, '0);
        write_reg(lpvo_pkg::CFG_POS_GAIN, '0);
        write_reg(lpvo_pkg::CFG_PV_GAIN, '0);
        write_reg(lpvo_pkg::CFG_VEL_GAIN, '0);
        send_sample('{DT_MAX, 32'sh0010_0000, -32'sh0008_0000, 32'sh0004_0000});
        // top of the documented ranges: unit gains, largest reciprocals
        write_reg(lpvo_pkg::CFG_INV_TAU, 32'h00FF_FFFF);
        write_reg(lpvo_pkg::CFG_POS_GAIN, 32'd65536);
        write_reg(lpvo_pkg::CFG_PV_GAIN, 32'h00FF_FFFF);
        write_reg(lpvo_pkg::CFG_VEL_GAIN, 32'd65536);
        send_sample('{16'd3277, 32'sh0004_0000, 32'sh0001_0000, 32'sh0002_0000});
        send_sample('{DT_MAX, 32'sd0, 32'sd0, 32'sd0});
    endtask

    task automatic test_initial_load();
        write_reg(lpvo_pkg::CFG_INV_TAU, 32'(lpvo_pkg::INV_TAU_RST));
        write_reg(lpvo_pkg::CFG_POS_GAIN, 32'(lpvo_pkg::POS_GAIN_RST));
        write_reg(lpvo_pkg::CFG_PV_GAIN, 32'(lpvo_pkg::PV_GAIN_RST));
        write_reg(lpvo_pkg::CFG_VEL_GAIN, 32'(lpvo_pkg::VEL_GAIN_RST));
        // command minus velocity spans the full 33-bit difference
        write_reg(lpvo_pkg::CFG_INIT_POS, V_MAX);
        write_reg(lpvo_pkg::CFG_INIT_VEL, V_MIN);
        send_sample('{DT_MAX, V_MIN, V_MAX, V_MAX});
        write_reg(lpvo_pkg::CFG_INIT_POS, V_MIN);
        write_reg(lpvo_pkg::CFG_INIT_VEL, V_MAX);
        send_sample('{DT_MAX, V_MAX, V_MIN, V_MIN});
        send_sample('{16'd0, V_MAX, V_MIN, V_MIN});
    endtask

    task automatic test_unknown_register();
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        send_sample('{16'd655, 32'sd0, 32'sd0, 32'sd0});
    endtask

    // ---- random test: segments with fresh settings, stimulus follows the estimates ----

    task automatic test_random_phase(input int send_pct, input int recv_pct);
        set_idling(send_pct, recv_pct);
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_reg(lpvo_pkg::CFG_INV_TAU, rand_reg_value(lpvo_pkg::CFG_INV_TAU));
            write_reg(lpvo_pkg::CFG_POS_GAIN, rand_reg_value(lpvo_pkg::CFG_POS_GAIN));
            write_reg(lpvo_pkg::CFG_PV_GAIN, rand_reg_value(lpvo_pkg::CFG_PV_GAIN));
            write_reg(lpvo_pkg::CFG_VEL_GAIN, rand_reg_value(lpvo_pkg::CFG_VEL_GAIN));
            if ($urandom_range(1) != 0) begin
                write_reg(lpvo_pkg::CFG_INIT_POS, rand_reg_value(lpvo_pkg::CFG_INIT_POS));
                write_reg(lpvo_pkg::CFG_INIT_VEL, rand_reg_value(lpvo_pkg::CFG_INIT_VEL));
            end
            if ($urandom_range(3) == 0) begin
                write_reg(($urandom_range(1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
            end
            repeat (PHASE_ITEMS / SEGMENTS) send_sample(make_random_sample());
        end
    endtask

    // Receiver back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each estimate word with the oldest prediction
    always @(posedge i_clk) begin : check_estimates
        t_estimate_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_estimates.size() == 0) begin
                if (fail_count < MAX_REPORTS) begin
                    $error("estimate word with no prediction pending");
                end
                fail_count++;
            end else begin
                want = expected_estimates.pop_front();
                if (out_ch.estimated_pos !== want.estimated_pos) begin
                    report_mismatch("estimated_pos", want.estimated_pos, out_ch.estimated_pos);
                end
                if (out_ch.estimated_vel !== want.estimated_vel) begin
                    report_mismatch("estimated_vel", want.estimated_vel, out_ch.estimated_vel);
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** luenberger_position_velocity_observer_top: FAILED **");
        $finish;
    end

    initial begin : run_tests
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.time_step     = '0;
        in_ch.measured_pos  = '0;
        in_ch.measured_vel  = '0;
        in_ch.commanded_vel = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0, 0);
        test_reset_state();
        test_field_extremes();
        test_gain_extremes();
        test_initial_load();
        test_unknown_register();

        test_random_phase(0, 0);
        test_random_phase(73, 0);
        test_random_phase(0, 73);
        test_random_phase(25, 25);

        // drain outstanding estimates, then watch for stray words
        in_ch.valid <= 1'b0;
        while (expected_estimates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** luenberger_position_velocity_observer_top: PASSED **");
        end else begin
            $display("** luenberger_position_velocity_observer_top: FAILED **");
        end
        $finish;
    end

endmodule
